### design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// shared constants, codes and types of the leader point clusterer
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = 6;
  localparam int STAT_W     = 3;
  localparam int COUNT_W    = 7;
  localparam int THR_W      = 15;
  localparam int MINP_W     = 16;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_JOINED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK    = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_EMPTY = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd6;

  localparam logic [KIND_W-1:0] K_MEAN   = 3'd0;
  localparam logic [KIND_W-1:0] K_LAST   = 3'd1;
  localparam logic [KIND_W-1:0] K_LEFT   = 3'd2;
  localparam logic [KIND_W-1:0] K_RIGHT  = 3'd3;
  localparam logic [KIND_W-1:0] K_FRONT  = 3'd4;
  localparam logic [KIND_W-1:0] K_BACK   = 3'd5;
  localparam logic [KIND_W-1:0] K_BOTTOM = 3'd6;
  localparam logic [KIND_W-1:0] K_TOP    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTROID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PTS  = 2'd2;

  localparam logic [THR_W-1:0]  NEAR_RST     = 15'd26;
  localparam logic [THR_W-1:0]  CENTROID_RST = 15'd77;
  localparam logic [MINP_W-1:0] MIN_PTS_RST  = 16'd1;
  localparam logic [SIZE_W-1:0] SIZE_SAT     = 16'hFFFF;

  typedef struct packed {
    logic done;
    logic hit;
  } dist_res_t;

endpackage

### design/lpc_store.sv
// ----------------------------------------------------------------------------
// lpc_store
// cluster point memory (eight points per slot) and cluster size memory
// ----------------------------------------------------------------------------
module lpc_store #(
  parameter int SLOT_W = 6,
  parameter int SLOTS  = 64,
  parameter int PW     = 48
) (
  input  logic                                 clk,
  input  logic [SLOT_W+lpc_pkg::KIND_W-1:0]    addr,
  input  logic                                 pt_we,
  input  logic [PW-1:0]                        pt_wdata,
  output logic [PW-1:0]                        pt_rdata,
  input  logic                                 sz_we,
  input  logic [lpc_pkg::SIZE_W-1:0]           sz_wdata,
  output logic [lpc_pkg::SIZE_W-1:0]           sz_rdata
);

  logic [PW-1:0]              pt_mem [SLOTS*8];
  logic [lpc_pkg::SIZE_W-1:0] sz_mem [SLOTS];
  logic [SLOT_W-1:0]          slot;

  assign slot = addr[SLOT_W+lpc_pkg::KIND_W-1:lpc_pkg::KIND_W];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[addr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (sz_we) begin
      sz_mem[slot] <= sz_wdata;
    end
    sz_rdata <= sz_mem[slot];
  end

endmodule

### design/lpc_dist.sv
// ----------------------------------------------------------------------------
// lpc_dist
// squared distance test on one shared multiplier: threshold, then dx, dy, dz
// ----------------------------------------------------------------------------
module lpc_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [3*COORD_BITS-1:0]       a,
  input  logic [3*COORD_BITS-1:0]       p,
  input  logic [lpc_pkg::THR_W-1:0]     thr,
  output lpc_pkg::dist_res_t            res
);

  localparam int DW = COORD_BITS + 1;
  localparam int MW = (DW > lpc_pkg::THR_W) ? DW : lpc_pkg::THR_W;
  localparam int AW = 2 * MW + 2;

  logic [3*COORD_BITS-1:0]   a_r;
  logic [lpc_pkg::THR_W-1:0] thr_r;
  logic [2:0]                cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      hit_r;
  logic [2*MW-1:0]           prod_r;
  logic [2*MW-1:0]           thr_sq_r;
  logic [AW-1:0]             acc_r;
  logic [MW-1:0]             opv;
  logic [AW-1:0]             acc_sum;

  logic signed [COORD_BITS-1:0] a_c [3];
  logic signed [COORD_BITS-1:0] p_c [3];
  logic signed [DW-1:0]         diff [3];
  logic [DW-1:0]                mag [3];

  for (genvar i = 0; i < 3; i++) begin : g_coord
    assign a_c[i]  = a_r[i*COORD_BITS +: COORD_BITS];
    assign p_c[i]  = p[i*COORD_BITS +: COORD_BITS];
    assign diff[i] = DW'(a_c[i]) - DW'(p_c[i]);
    assign mag[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
  end

  always_comb begin
    case (cnt_r)
      3'd0:    opv = MW'(thr_r);
      3'd1:    opv = MW'(mag[0]);
      3'd2:    opv = MW'(mag[1]);
      3'd3:    opv = MW'(mag[2]);
      default: opv = '0;
    endcase
  end

  assign acc_sum = acc_r + AW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      a_r    <= a;
      thr_r  <= thr;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      prod_r <= opv * opv;
      cnt_r  <= cnt_r + 3'd1;
      case (cnt_r)
        3'd1: thr_sq_r <= prod_r;
        3'd2: acc_r    <= AW'(prod_r);
        3'd3: acc_r    <= acc_sum;
        3'd4: begin
          hit_r  <= acc_sum < AW'(thr_sq_r);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
        default: ;
      endcase
    end else begin
      done_r <= 1'b0;
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;

endmodule

### design/lpc_div.sv
// ----------------------------------------------------------------------------
// lpc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lpc_div #(
  parameter int NW = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NW-1:0]               num,
  input  logic [lpc_pkg::SIZE_W-1:0]  den,
  output logic [NW-1:0]               quo,
  output logic                        done
);

  localparam int DEN_W = lpc_pkg::SIZE_W;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    num_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      num_r  <= num;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      // remainder stays below den, so it fits in DEN_W bits
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
      num_r <= {num_r[NW-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

### design/leader_point_clusterer.sv
// add: stored points are tested in turn (one shared multiplier pass each), eight per cluster,
//   until one is near; a join then updates every entry, with one division per mean coordinate
// throughput: one request at a time; in_tready is high only while idle
// reset: synchronous active low; a sweep over the eight entries seeds slot 0 before ready
// ----------------------------------------------------------------------------
// leader_point_clusterer
// greedy single-pass clustering of 3-d points with a shared distance unit
// ----------------------------------------------------------------------------
module leader_point_clusterer #(
  parameter int MAX_CLUSTERS = lpc_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = lpc_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((12 + 3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((33 + 3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // op, point_x, point_y, point_z, point_finite, entry_index, entry_kind
  input  logic [IN_W-1:0]                   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, cluster_index, cluster_count, out_x, out_y, out_z, cluster_size,
  // qualifies
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_we,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CB     = COORD_BITS;
  localparam int PW     = 3 * CB;
  localparam int SLOT_W = $clog2(MAX_CLUSTERS);
  localparam int CW     = $clog2(MAX_CLUSTERS + 1);
  localparam int ADDR_W = SLOT_W + lpc_pkg::KIND_W;
  localparam int DW     = CB + 1;
  localparam int NW     = ((DW > lpc_pkg::SIZE_W) ? DW : lpc_pkg::SIZE_W) + 1;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_SC_WT   = 5'd2;
  localparam logic [4:0] S_SC_GO   = 5'd3;
  localparam logic [4:0] S_SC_DIST = 5'd4;
  localparam logic [4:0] S_UP0     = 5'd5;
  localparam logic [4:0] S_UP_WT   = 5'd6;
  localparam logic [4:0] S_UP_CALC = 5'd7;
  localparam logic [4:0] S_DIV_GO  = 5'd8;
  localparam logic [4:0] S_DIV_WT  = 5'd9;
  localparam logic [4:0] S_UP_MW   = 5'd10;
  localparam logic [4:0] S_NEW     = 5'd11;
  localparam logic [4:0] S_RF0     = 5'd12;
  localparam logic [4:0] S_RF1     = 5'd13;
  localparam logic [4:0] S_RF2     = 5'd14;
  localparam logic [4:0] S_RF3     = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  // input fields
  logic [lpc_pkg::OP_W-1:0]   in_op;
  logic [PW-1:0]              in_point;
  logic                       in_finite;
  logic [lpc_pkg::IDX_W-1:0]  in_idx;
  logic [lpc_pkg::KIND_W-1:0] in_kind;

  assign in_op     = in_tdata[1:0];
  assign in_point  = in_tdata[2 +: PW];
  assign in_finite = in_tdata[2 + PW];
  assign in_idx    = in_tdata[3 + PW +: lpc_pkg::IDX_W];
  assign in_kind   = in_tdata[9 + PW +: lpc_pkg::KIND_W];

  logic [lpc_pkg::THR_W-1:0]  near_r;
  logic [lpc_pkg::THR_W-1:0]  cent_r;
  logic [lpc_pkg::MINP_W-1:0] minp_r;

  logic [4:0]                 state_r;
  logic [PW-1:0]              p_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [lpc_pkg::KIND_W-1:0] ent_r;
  logic [CW-1:0]              total_r;
  logic                       clr_r;
  logic [lpc_pkg::SIZE_W-1:0] n_r;
  logic [lpc_pkg::SIZE_W-1:0] n_nxt;
  logic [PW-1:0]              a_r;
  logic [1:0]                 c_r;
  logic [CB-1:0]              new_r [3];

  logic [lpc_pkg::STAT_W-1:0] res_status_r;
  logic [lpc_pkg::IDX_W-1:0]  res_index_r;
  logic [PW-1:0]              res_pt_r;
  logic [lpc_pkg::SIZE_W-1:0] res_size_r;
  logic                       res_nz_r;
  logic                       res_full_r;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;

  // memory port
  logic [ADDR_W-1:0]          addr;
  logic                       pt_we;
  logic [PW-1:0]              pt_wdata;
  logic [PW-1:0]              pt_rdata;
  logic                       sz_we;
  logic [lpc_pkg::SIZE_W-1:0] sz_wdata;
  logic [lpc_pkg::SIZE_W-1:0] sz_rdata;

  lpc_pkg::dist_res_t         dist_res;
  logic [lpc_pkg::THR_W-1:0]  dist_thr;
  logic [NW-1:0]              div_num;
  logic [NW-1:0]              div_quo;
  logic                       div_done;

  logic signed [CB-1:0] p_c  [3];
  logic signed [CB-1:0] rd_c [3];
  logic signed [CB-1:0] a_c  [3];

  for (genvar i = 0; i < 3; i++) begin : g_coord
    assign p_c[i]  = p_r[i*CB +: CB];
    assign rd_c[i] = pt_rdata[i*CB +: CB];
    assign a_c[i]  = a_r[i*CB +: CB];
  end

  assign addr = {slot_r, ent_r};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= lpc_pkg::NEAR_RST;
      cent_r <= lpc_pkg::CENTROID_RST;
      minp_r <= lpc_pkg::MIN_PTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpc_pkg::CFG_NEAR:     near_r <= cfg_wdata[lpc_pkg::THR_W-1:0];
        lpc_pkg::CFG_CENTROID: cent_r <= cfg_wdata[lpc_pkg::THR_W-1:0];
        lpc_pkg::CFG_MIN_PTS:  minp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // last-point and extreme update of a stored point on join
  logic [PW-1:0] upd_pt;
  always_comb begin
    upd_pt = pt_rdata;
    case (ent_r)
      lpc_pkg::K_LAST:   upd_pt = p_r;
      lpc_pkg::K_LEFT:   if (rd_c[1] < p_c[1]) upd_pt = p_r;
      lpc_pkg::K_RIGHT:  if (rd_c[1] > p_c[1]) upd_pt = p_r;
      lpc_pkg::K_FRONT:  if (rd_c[0] > p_c[0]) upd_pt = p_r;
      lpc_pkg::K_BACK:   if (rd_c[0] < p_c[0]) upd_pt = p_r;
      lpc_pkg::K_BOTTOM: if (rd_c[2] > p_c[2]) upd_pt = p_r;
      lpc_pkg::K_TOP:    if (rd_c[2] < p_c[2]) upd_pt = p_r;
      default: ;
    endcase
  end

  // mean step: m + round((p - m) / n), ties away from zero
  logic signed [CB-1:0] m_sel;
  logic signed [CB-1:0] pc_sel;
  logic signed [DW-1:0] d;
  logic                 d_neg;
  logic [DW-1:0]        d_mag;
  logic signed [NW:0]   q_s;
  logic signed [NW:0]   mean_sum;

  always_comb begin
    case (c_r)
      2'd0:    begin m_sel = a_c[0]; pc_sel = p_c[0]; end
      2'd1:    begin m_sel = a_c[1]; pc_sel = p_c[1]; end
      default: begin m_sel = a_c[2]; pc_sel = p_c[2]; end
    endcase
  end

  assign d        = DW'(pc_sel) - DW'(m_sel);
  assign d_neg    = d[DW-1];
  assign d_mag    = d_neg ? DW'(-d) : DW'(d);
  assign div_num  = NW'(d_mag) + NW'(n_r >> 1);
  assign q_s      = $signed({1'b0, div_quo});
  assign mean_sum = (NW+1)'(m_sel) + (d_neg ? -q_s : q_s);

  assign n_nxt = (sz_rdata == lpc_pkg::SIZE_SAT) ? sz_rdata
                                                 : sz_rdata + lpc_pkg::SIZE_W'(1);

  always_comb begin
    pt_we    = 1'b0;
    pt_wdata = p_r;
    sz_we    = 1'b0;
    sz_wdata = lpc_pkg::SIZE_W'(1);
    unique case (state_r)
      S_INIT: begin
        pt_we    = 1'b1;
        pt_wdata = '0;
        sz_we    = 1'b1;
      end
      S_NEW: begin
        pt_we = 1'b1;
        sz_we = 1'b1;
      end
      S_UP0: begin
        sz_we    = 1'b1;
        sz_wdata = n_nxt;
      end
      S_UP_CALC: begin
        pt_we    = ent_r != lpc_pkg::K_MEAN;
        pt_wdata = upd_pt;
      end
      S_UP_MW: begin
        pt_we    = 1'b1;
        pt_wdata = {new_r[2], new_r[1], new_r[0]};
      end
      default: ;
    endcase
  end

  assign dist_thr = (ent_r == lpc_pkg::K_MEAN) ? cent_r : near_r;

  lpc_store #(
    .SLOT_W (SLOT_W),
    .SLOTS  (MAX_CLUSTERS),
    .PW     (PW)
  ) u_store (
    .clk      (clk),
    .addr     (addr),
    .pt_we    (pt_we),
    .pt_wdata (pt_wdata),
    .pt_rdata (pt_rdata),
    .sz_we    (sz_we),
    .sz_wdata (sz_wdata),
    .sz_rdata (sz_rdata)
  );

  lpc_dist #(
    .COORD_BITS (CB)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SC_GO),
    .a     (pt_rdata),
    .p     (p_r),
    .thr   (dist_thr),
    .res   (dist_res)
  );

  lpc_div #(
    .NW (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV_GO),
    .num   (div_num),
    .den   (n_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  logic last_slot;
  logic room;
  logic read_ok;
  logic qual;

  assign last_slot = (CW'(slot_r) + CW'(1)) == total_r;
  assign room      = 32'(total_r) < 32'(MAX_CLUSTERS);
  assign read_ok   = 32'(in_idx) < 32'(total_r);
  assign qual      = res_full_r && res_nz_r && (res_size_r > minp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      slot_r      <= '0;
      ent_r       <= '0;
      total_r     <= CW'(1);
      clr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is handled below
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          ent_r <= ent_r + lpc_pkg::KIND_W'(1);
          if (ent_r == lpc_pkg::K_TOP) begin
            clr_r <= 1'b0;
            if (clr_r) begin
              res_status_r <= lpc_pkg::ST_CLEARED;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            p_r         <= in_point;
            res_full_r  <= 1'b0;
            res_index_r <= '0;
            case (in_op)
              lpc_pkg::OP_CLEAR: begin
                total_r <= CW'(1);
                slot_r  <= '0;
                ent_r   <= '0;
                clr_r   <= 1'b1;
                state_r <= S_INIT;
              end
              lpc_pkg::OP_READ: begin
                res_index_r <= in_idx;
                if (read_ok) begin
                  slot_r       <= SLOT_W'(in_idx);
                  ent_r        <= in_kind;
                  res_status_r <= lpc_pkg::ST_READ_OK;
                  res_full_r   <= 1'b1;
                  state_r      <= S_RF0;
                end else begin
                  res_status_r <= lpc_pkg::ST_READ_EMPTY;
                  state_r      <= S_OUT;
                end
              end
              lpc_pkg::OP_ADD: begin
                if (in_finite) begin
                  slot_r  <= '0;
                  ent_r   <= '0;
                  state_r <= S_SC_WT;
                end else begin
                  res_status_r <= lpc_pkg::ST_IGNORED;
                  state_r      <= S_OUT;
                end
              end
              default: begin
                res_status_r <= lpc_pkg::ST_IGNORED;
                state_r      <= S_OUT;
              end
            endcase
          end
        end
        S_SC_WT: state_r <= S_SC_GO;
        S_SC_GO: state_r <= S_SC_DIST;
        S_SC_DIST: begin
          if (dist_res.done) begin
            if (dist_res.hit) begin
              state_r <= S_UP0;
            end else if (ent_r == lpc_pkg::K_TOP) begin
              ent_r <= '0;
              if (!last_slot) begin
                slot_r  <= slot_r + SLOT_W'(1);
                state_r <= S_SC_WT;
              end else if (room) begin
                slot_r  <= SLOT_W'(total_r);
                total_r <= total_r + CW'(1);
                state_r <= S_NEW;
              end else begin
                res_status_r <= lpc_pkg::ST_DROPPED;
                state_r      <= S_OUT;
              end
            end else begin
              ent_r   <= ent_r + lpc_pkg::KIND_W'(1);
              state_r <= S_SC_WT;
            end
          end
        end
        S_UP0: begin
          n_r     <= n_nxt;
          ent_r   <= '0;
          state_r <= S_UP_WT;
        end
        S_UP_WT: state_r <= S_UP_CALC;
        S_UP_CALC: begin
          if (ent_r == lpc_pkg::K_MEAN) begin
            a_r     <= pt_rdata;
            c_r     <= 2'd0;
            state_r <= S_DIV_GO;
          end else if (ent_r == lpc_pkg::K_TOP) begin
            ent_r        <= lpc_pkg::K_MEAN;
            res_status_r <= lpc_pkg::ST_JOINED;
            res_index_r  <= lpc_pkg::IDX_W'(slot_r);
            res_full_r   <= 1'b1;
            state_r      <= S_RF0;
          end else begin
            ent_r   <= ent_r + lpc_pkg::KIND_W'(1);
            state_r <= S_UP_WT;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WT;
        S_DIV_WT: begin
          if (div_done) begin
            new_r[c_r] <= mean_sum[CB-1:0];
            if (c_r == 2'd2) begin
              state_r <= S_UP_MW;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_UP_MW: begin
          ent_r   <= ent_r + lpc_pkg::KIND_W'(1);
          state_r <= S_UP_WT;
        end
        S_NEW: begin
          if (ent_r == lpc_pkg::K_TOP) begin
            ent_r        <= lpc_pkg::K_MEAN;
            res_status_r <= lpc_pkg::ST_NEW;
            res_index_r  <= lpc_pkg::IDX_W'(slot_r);
            res_full_r   <= 1'b1;
            state_r      <= S_RF0;
          end else begin
            ent_r <= ent_r + lpc_pkg::KIND_W'(1);
          end
        end
        S_RF0: state_r <= S_RF1;
        S_RF1: begin
          res_pt_r   <= pt_rdata;
          res_size_r <= sz_rdata;
          ent_r      <= lpc_pkg::K_MEAN;
          state_r    <= S_RF2;
        end
        S_RF2: state_r <= S_RF3;
        S_RF3: begin
          res_nz_r <= pt_rdata != '0;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_W'({qual,
                                   res_full_r ? res_size_r : lpc_pkg::SIZE_W'(0),
                                   res_full_r ? res_pt_r : PW'(0),
                                   lpc_pkg::COUNT_W'(total_r),
                                   res_index_r,
                                   res_status_r});
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### design/lpc_chk.sv
// ----------------------------------------------------------------------------
// lpc_chk
// port-level checks on the leader point clusterer
// ----------------------------------------------------------------------------
module lpc_chk #(
  parameter int COORD_BITS = lpc_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ((33 + 3 * COORD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [lpc_pkg::STAT_W-1:0]  stat;
  logic [lpc_pkg::COUNT_W-1:0] count;

  assign stat  = out_tdata[2:0];
  assign count = out_tdata[15:9];

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after a request");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stat != 3'd7)
    else $error("undefined status");

  // a cleared table holds only the seed cluster
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat == lpc_pkg::ST_CLEARED |-> count == 7'd1)
    else $error("clear left wrong count");

endmodule

bind leader_point_clusterer lpc_chk #(.COORD_BITS(COORD_BITS)) u_lpc_chk (.*);

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the leader point clusterer: directed clear, add,
// read and table-full cases, threshold settings, a long output stall, then
// clustered random point clouds checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb;

  localparam int NCL    = 64;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 88;
  localparam int N_RAND = 620;

  // op code with no defined meaning, answered as ignored
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [2:0]         st;
    logic [5:0]         ci;
    logic [6:0]         cnt;
    logic signed [15:0] x, y, z;
    logic [15:0]        sz;
    logic               q;
  } result_t;

  logic             clk, rst_n;
  logic             in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_W-1:0]  in_tdata;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_wdata;

  leader_point_clusterer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predicted table
  longint      pts[NCL][8][3];
  int unsigned sizes[NCL];
  int          total;
  longint      near_thr, cent_thr, min_pts;

  result_t exp_results[$];
  int      errors;
  int      items_sent;
  int      burst_left;
  int      hold_req, hold_seen, hold_cnt, rx_mode, rx_phase;
  longint  centres[6][3];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb: errors");
    $finish;
  end

  function automatic bit bool_near(int s, int k, longint p[3], longint thr);
    longint sum, d;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d = pts[s][k][i] - p[i];
      sum += d * d;
    end
    return sum < thr * thr;
  endfunction

  function automatic longint mean_step(longint d, longint n);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag + n / 2) / n;
    return (d < 0) ? -q : q;
  endfunction

  function automatic void fill_point(ref result_t r, input int s, input int k);
    r.x  = 16'(pts[s][k][0]);
    r.y  = 16'(pts[s][k][1]);
    r.z  = 16'(pts[s][k][2]);
    r.sz = 16'(sizes[s]);
    r.q  = (pts[s][lpc_pkg::K_MEAN][0] != 0 || pts[s][lpc_pkg::K_MEAN][1] != 0 ||
            pts[s][lpc_pkg::K_MEAN][2] != 0) && (sizes[s] > min_pts);
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < NCL; s++) begin
      sizes[s] = 0;
      for (int k = 0; k < 8; k++)
        for (int i = 0; i < 3; i++) pts[s][k][i] = 0;
    end
    sizes[0] = 1;
    total = 1;
  endfunction

  function automatic result_t cluster_outcome(logic [1:0] op, longint px, longint py,
                                              longint pz, bit fin, int idx, int kind);
    result_t r;
    longint  p[3];
    int      s;
    r = '{default: '0};
    p[0] = px; p[1] = py; p[2] = pz;
    if (op == lpc_pkg::OP_CLEAR) begin
      clear_table();
      r.st = lpc_pkg::ST_CLEARED;
    end else if (op == lpc_pkg::OP_READ) begin
      r.ci = 6'(idx);
      if (idx < total) begin
        r.st = lpc_pkg::ST_READ_OK;
        fill_point(r, idx, kind);
      end else begin
        r.st = lpc_pkg::ST_READ_EMPTY;
      end
    end else if (op != lpc_pkg::OP_ADD || !fin) begin
      r.st = lpc_pkg::ST_IGNORED;
    end else begin
      for (s = 0; s < total; s++)
        if (bool_near(s, lpc_pkg::K_LAST, p, near_thr) ||
            bool_near(s, lpc_pkg::K_MEAN, p, cent_thr) ||
            bool_near(s, lpc_pkg::K_LEFT, p, near_thr) ||
            bool_near(s, lpc_pkg::K_RIGHT, p, near_thr) ||
            bool_near(s, lpc_pkg::K_BOTTOM, p, near_thr) ||
            bool_near(s, lpc_pkg::K_TOP, p, near_thr) ||
            bool_near(s, lpc_pkg::K_FRONT, p, near_thr) ||
            bool_near(s, lpc_pkg::K_BACK, p, near_thr))
          break;
      if (s < total) begin
        if (sizes[s] < 65535) sizes[s]++;
        pts[s][lpc_pkg::K_LAST] = p;
        if (pts[s][lpc_pkg::K_LEFT][1] < py)   pts[s][lpc_pkg::K_LEFT] = p;
        if (pts[s][lpc_pkg::K_RIGHT][1] > py)  pts[s][lpc_pkg::K_RIGHT] = p;
        if (pts[s][lpc_pkg::K_FRONT][0] > px)  pts[s][lpc_pkg::K_FRONT] = p;
        if (pts[s][lpc_pkg::K_BACK][0] < px)   pts[s][lpc_pkg::K_BACK] = p;
        if (pts[s][lpc_pkg::K_BOTTOM][2] > pz) pts[s][lpc_pkg::K_BOTTOM] = p;
        if (pts[s][lpc_pkg::K_TOP][2] < pz)    pts[s][lpc_pkg::K_TOP] = p;
        for (int i = 0; i < 3; i++)
          pts[s][lpc_pkg::K_MEAN][i] += mean_step(p[i] - pts[s][lpc_pkg::K_MEAN][i],
                                                  sizes[s]);
        r.st = lpc_pkg::ST_JOINED;
        r.ci = 6'(s);
        fill_point(r, s, lpc_pkg::K_MEAN);
      end else if (total < NCL) begin
        s = total++;
        for (int k = 0; k < 8; k++) pts[s][k] = p;
        sizes[s] = 1;
        r.st = lpc_pkg::ST_NEW;
        r.ci = 6'(s);
        fill_point(r, s, lpc_pkg::K_MEAN);
      end else begin
        r.st = lpc_pkg::ST_DROPPED;
      end
    end
    r.cnt = 7'(total);
    return r;
  endfunction

  task automatic send_req(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z, bit fin, int idx, int kind);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, 3'(kind), 6'(idx), fin, z, y, x, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_results.insert(exp_results.size(), cluster_outcome(op, x, y, z, fin, idx, kind));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(0, 10);
    end
  endtask

  task automatic add_pt(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    send_req(lpc_pkg::OP_ADD, x, y, z, 1'b1, $urandom_range(0, 63), $urandom_range(0, 7));
  endtask

  task automatic read_ent(int idx, int kind);
    send_req(lpc_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom_range(0, 1)), idx, kind);
  endtask

  task automatic clear_tab();
    send_req(lpc_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 7));
  endtask

  // wait until every request has answered, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limits(int nr, int ce, int mp);
    settle();
    cfg_we <= 1'b1; cfg_index <= lpc_pkg::CFG_NEAR; cfg_wdata <= 16'(nr);
    @(posedge clk);
    cfg_index <= lpc_pkg::CFG_CENTROID; cfg_wdata <= 16'(ce);
    @(posedge clk);
    cfg_index <= lpc_pkg::CFG_MIN_PTS; cfg_wdata <= 16'(mp);
    @(posedge clk);
    cfg_we <= 1'b0;
    near_thr = nr & 16'h7FFF;
    cent_thr = ce & 16'h7FFF;
    min_pts  = mp;
  endtask

  // output side stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 600;
    end
    if (rx_phase == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_phase = $urandom_range(8, 80);
    end else begin
      rx_phase--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
        errors++;
      end else begin
        e = exp_results.pop_front();
        check_field("status", e.st, out_tdata[2:0]);
        check_field("cluster_index", e.ci, out_tdata[8:3]);
        check_field("cluster_count", e.cnt, out_tdata[15:9]);
        check_field("out_x", e.x, $signed(out_tdata[31:16]));
        check_field("out_y", e.y, $signed(out_tdata[47:32]));
        check_field("out_z", e.z, $signed(out_tdata[63:48]));
        check_field("cluster_size", e.sz, out_tdata[79:64]);
        check_field("qualifies", e.q, out_tdata[80]);
      end
    end
  end

  task automatic test_after_reset();
    for (int k = 0; k < 8; k++) read_ent(0, k);
    read_ent(1, lpc_pkg::K_MEAN);
    read_ent(63, lpc_pkg::K_TOP);
  endtask

  task automatic test_basic_ops();
    add_pt(5, -7, 3);          // joins the seed at the origin
    add_pt(1000, 2000, -3000); // opens a cluster
    add_pt(1010, 1995, -2990); // joins, mean rounding
    add_pt(1003, 2011, -3013);
    send_req(lpc_pkg::OP_ADD, 1000, 2000, -3000, 1'b0, 0, 0);
    send_req(OP_UNKNOWN, 1000, 2000, -3000, 1'b1, 0, 0);
    for (int k = 0; k < 8; k++) read_ent(1, k);
    add_pt(32767, 32767, 32767);
    add_pt(-32768, -32768, -32768);
    read_ent(3, lpc_pkg::K_LAST);
    read_ent(4, lpc_pkg::K_MEAN);
    clear_tab();
    read_ent(1, lpc_pkg::K_MEAN);
  endtask

  task automatic test_limits();
    set_limits(32767, 32767, 0);
    add_pt(32767, -32768, 32767);
    add_pt(-32768, 32767, -32768);
    add_pt(100, 100, 100);
    read_ent(0, lpc_pkg::K_LEFT);
    read_ent(0, lpc_pkg::K_FRONT);
    set_limits(0, 77, 65535);
    add_pt(2, 2, 2);
    read_ent(0, lpc_pkg::K_MEAN);
    set_limits(26, 0, 2);
    clear_tab();
    add_pt(20, 0, 0);
    add_pt(-20, 10, 5);
    add_pt(-5, -5, -5);
    read_ent(0, lpc_pkg::K_RIGHT);
  endtask

  task automatic test_table_full();
    set_limits(0, 0, 1);
    clear_tab();
    for (int i = 1; i <= NCL; i++) add_pt(16'(i * 500 - 16000), 16'(-i * 300), 16'(i * 7));
    read_ent(63, lpc_pkg::K_BOTTOM);
    read_ent(62, lpc_pkg::K_MEAN);
  endtask

  task automatic test_output_stall();
    set_limits(26, 77, 1);
    clear_tab();
    hold_req++;
    for (int i = 0; i < 12; i++) add_pt(16'(i * 11), 16'(-i * 5), 40);
  endtask

  task automatic test_random_clouds();
    int   n, r;
    logic signed [15:0] x, y, z;
    n = 0;
    while (n < N_RAND) begin
      r = $urandom_range(0, 9);
      if (r == 0) set_limits(0, 0, $urandom_range(0, 65535));
      else if (r == 1) set_limits(32767, $urandom_range(0, 32767), $urandom_range(0, 3));
      else set_limits($urandom_range(10, 200), $urandom_range(20, 400),
                      $urandom_range(0, 6));
      for (int c = 0; c < 6; c++)
        for (int i = 0; i < 3; i++) centres[c][i] = $signed(16'($urandom_range(0, 60000)))
                                                    / 2 * 2 - 0;
      clear_tab();
      n++;
      for (int j = 0; j < 30; j++) begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          int c;
          c = $urandom_range(0, 5);
          x = 16'(centres[c][0] + $urandom_range(0, 120) - 60);
          y = 16'(centres[c][1] + $urandom_range(0, 120) - 60);
          z = 16'(centres[c][2] + $urandom_range(0, 120) - 60);
          add_pt(x, y, z);
        end else if (r < 15) begin
          read_ent($urandom_range(0, 63), $urandom_range(0, 7));
        end else if (r < 17) begin
          add_pt(16'($urandom), 16'($urandom), 16'($urandom));
        end else if (r == 17) begin
          send_req($urandom_range(0, 1) ? lpc_pkg::OP_ADD : OP_UNKNOWN,
                   16'($urandom), 16'($urandom), 16'($urandom),
                   1'b0, $urandom_range(0, 63), $urandom_range(0, 7));
        end else if (r == 18) begin
          send_req(OP_UNKNOWN, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1,
                   $urandom_range(0, 63), $urandom_range(0, 7));
        end else begin
          read_ent($urandom_range(0, 7), $urandom_range(0, 7));
        end
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    hold_req = 0; hold_seen = 0; hold_cnt = 0; rx_mode = 0; rx_phase = 0;
    clear_table();
    near_thr = 26; cent_thr = 77; min_pts = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_basic_ops();
    test_limits();
    test_table_full();
    test_output_stall();
    test_random_clouds();
    settle();
    repeat (50) @(posedge clk);

    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
